// File: rtl/lrv_pkg.sv
package lrv_pkg;

    localparam int ROUTES = 16;
    localparam int SLOT_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int USED_W = $clog2(ROUTES + 1);

    localparam int ENTRY_IDX_W = 4;
    localparam int COUNT_W     = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int STATUS_W    = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 4'd1;
    localparam logic [STATUS_W-1:0] ST_OTHER_GRP = 4'd2;
    localparam logic [STATUS_W-1:0] ST_STALE     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_CONFLICT  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_SELF      = 4'd5;
    localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_LIMIT     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_BAD_ENTRY = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_HIGH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_NODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MINIMUM_EPOCH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REDIRECT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE_COUNT    = 3'd5;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    typedef struct packed {
        logic [63:0] node;
        logic [31:0] addr;
        logic [15:0] port;
    } route_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic              active;
        logic              hit;
        logic [USED_W-1:0] left;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       addr;
        logic [15:0]       port;
    } probe_t;

endpackage

// File: rtl/lrv_if.sv
interface lrv_req_if;
    import lrv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [63:0]            group_hi_in;
    logic [63:0]            group_lo_in;
    logic [63:0]            leader_node;
    logic [63:0]            term_in;
    logic [63:0]            epoch_in;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [63:0]            entry_node;
    logic [31:0]            entry_address;
    logic [15:0]            entry_port;

    modport source (
        output valid, mode, group_hi_in, group_lo_in, leader_node, term_in,
               epoch_in, entry_index, entry_node, entry_address, entry_port,
        input  ready
    );
    modport sink (
        input  valid, mode, group_hi_in, group_lo_in, leader_node, term_in,
               epoch_in, entry_index, entry_node, entry_address, entry_port,
        output ready
    );
endinterface

interface lrv_rsp_if;
    import lrv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [ENTRY_IDX_W-1:0] route_slot;
    logic [31:0]            target_address;
    logic [15:0]            target_port;
    logic [COUNT_W-1:0]     redirect_count;

    modport source (
        output valid, status, route_slot, target_address, target_port, redirect_count,
        input  ready
    );
    modport sink (
        input  valid, status, route_slot, target_address, target_port, redirect_count,
        output ready
    );
endinterface

interface lrv_cfg_if;
    import lrv_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/lrv_cell.sv
module lrv_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  lrv_pkg::route_t wr_route,
    input  logic [63:0]     leader,
    input  lrv_pkg::probe_t probe_in,
    output lrv_pkg::probe_t probe_out
);
    import lrv_pkg::*;

    route_t entry_reg;
    probe_t probe_reg;
    probe_t probe_next;

    always_comb
    begin
        probe_next = probe_in;
        if (probe_in.left != '0)
        begin
            probe_next.left = probe_in.left - 1'b1;
        end
        // first match wins; a hit freezes the slot and route
        if (probe_in.active && !probe_in.hit && probe_in.left != '0
            && entry_reg.node == leader)
        begin
            probe_next.hit  = 1'b1;
            probe_next.addr = entry_reg.addr;
            probe_next.port = entry_reg.port;
        end
        else if (!probe_in.hit)
        begin
            probe_next.slot = probe_in.slot + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_route;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

// File: rtl/lrv_chain.sv
module lrv_chain (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [lrv_pkg::SLOT_W-1:0] wr_slot,
    input  lrv_pkg::route_t           wr_route,
    input  logic [63:0]               leader,
    input  lrv_pkg::probe_t           probe_in,
    output lrv_pkg::probe_t           probe_out
);
    import lrv_pkg::*;

    probe_t link [ROUTES+1];

    assign link[0] = probe_in;

    for (genvar k = 0; k < ROUTES; k++)
    begin : g_cell
        lrv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en && wr_slot == SLOT_W'(k)),
            .wr_route  (wr_route),
            .leader    (leader),
            .probe_in  (link[k]),
            .probe_out (link[k+1])
        );
    end

    assign probe_out = link[ROUTES];

endmodule

// File: rtl/leader_redirect_validator.sv
// Channel  Modport  Carries
// req      sink     one item: route load (mode 0) or redirect check (mode 1)
// rsp      source   one result per item: status, slot, route, redirect count
// cfg      sink     register write: index and 64-bit data, always ready
//
// A route load or a check that fails before the table search returns its result
// in the cycle after acceptance. A check that reaches the search walks a token down
// the row of ROUTES route cells, one cell per cycle, through a launch register,
// the cell registers and the result registers. One item is in flight at a time: req
// is ready only when no item is being worked on and no result is waiting on rsp.
// Reset clears the authority and the count, sets the configuration registers to
// defaults; route slots hold what was last loaded and are undefined until written.
module leader_redirect_validator (
    input  logic      clk,
    input  logic      rst_n,
    lrv_req_if.sink   req,
    lrv_rsp_if.source rsp,
    lrv_cfg_if.sink   cfg
);
    import lrv_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [63:0]        group_high_reg, group_low_reg, initial_node_reg, min_epoch_reg;
    logic [COUNT_W-1:0] limit_reg;
    logic [4:0]         route_count_reg;

    logic               have_auth_reg, have_auth_next;
    logic [63:0]        last_term_reg, last_term_next;
    logic [63:0]        last_epoch_reg, last_epoch_next;
    logic [63:0]        last_leader_reg, last_leader_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               launch_reg, launch_next;

    logic [63:0] leader_reg, term_reg, epoch_reg;

    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [ENTRY_IDX_W-1:0] slot_reg, slot_next;
    logic [31:0]            addr_reg, addr_next;
    logic [15:0]            port_reg, port_next;

    logic              accept;
    logic              load_bad;
    logic              load_wr;
    logic [63:0]       current;
    logic [STATUS_W-1:0] chk_status;
    logic [USED_W-1:0] used;
    logic              limit_hit;
    probe_t            chain_in, chain_out;
    route_t            wr_route;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_DONE);
    assign cfg.ready = 1'b1;

    assign rsp.status         = status_reg;
    assign rsp.route_slot     = slot_reg;
    assign rsp.target_address = addr_reg;
    assign rsp.target_port    = port_reg;
    assign rsp.redirect_count = count_reg;

    assign load_bad = req.entry_node == '0 || req.entry_address == '0
                      || req.entry_port == '0 || int'(req.entry_index) >= ROUTES;
    assign load_wr  = accept && req.mode == MODE_LOAD && !load_bad;

    assign wr_route.node = req.entry_node;
    assign wr_route.addr = req.entry_address;
    assign wr_route.port = req.entry_port;

    assign current   = have_auth_reg ? last_leader_reg : initial_node_reg;
    assign used      = (int'(route_count_reg) > ROUTES) ? USED_W'(ROUTES)
                                                        : USED_W'(route_count_reg);
    assign limit_hit = count_reg >= limit_reg || count_reg == COUNT_MAX;

    // checks ahead of the table search, in priority order
    always_comb
    begin
        if ((req.group_hi_in == '0 && req.group_lo_in == '0) || req.leader_node == '0
            || req.term_in == '0 || req.epoch_in == '0)
        begin
            chk_status = ST_MALFORMED;
        end
        else if (req.group_hi_in != group_high_reg || req.group_lo_in != group_low_reg)
        begin
            chk_status = ST_OTHER_GRP;
        end
        else if (req.epoch_in < min_epoch_reg
                 || (have_auth_reg && (req.epoch_in < last_epoch_reg
                                       || req.term_in < last_term_reg)))
        begin
            chk_status = ST_STALE;
        end
        else if (have_auth_reg && req.term_in == last_term_reg
                 && req.leader_node != last_leader_reg)
        begin
            chk_status = ST_CONFLICT;
        end
        else if (req.leader_node == current)
        begin
            chk_status = ST_SELF;
        end
        else
        begin
            chk_status = ST_OK;
        end
    end

    always_comb
    begin
        chain_in        = '0;
        chain_in.active = launch_reg;
        chain_in.left   = used;
    end

    lrv_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (load_wr),
        .wr_slot   (SLOT_W'(req.entry_index)),
        .wr_route  (wr_route),
        .leader    (leader_reg),
        .probe_in  (chain_in),
        .probe_out (chain_out)
    );

    always_comb
    begin
        state_next       = state_reg;
        have_auth_next   = have_auth_reg;
        last_term_next   = last_term_reg;
        last_epoch_next  = last_epoch_reg;
        last_leader_next = last_leader_reg;
        count_next       = count_reg;
        launch_next      = 1'b0;
        status_next      = status_reg;
        slot_next        = slot_reg;
        addr_next        = addr_reg;
        port_next        = port_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    slot_next = '0;
                    addr_next = '0;
                    port_next = '0;
                    if (req.mode == MODE_LOAD)
                    begin
                        status_next = load_bad ? ST_BAD_ENTRY : ST_OK;
                        slot_next   = load_bad ? '0 : req.entry_index;
                        state_next  = S_DONE;
                    end
                    else if (chk_status != ST_OK)
                    begin
                        status_next = chk_status;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (chain_out.active)
                begin
                    state_next = S_DONE;
                    if (!chain_out.hit)
                    begin
                        status_next = ST_NO_ROUTE;
                    end
                    else if (limit_hit)
                    begin
                        status_next = ST_LIMIT;
                    end
                    else
                    begin
                        status_next      = ST_OK;
                        slot_next        = ENTRY_IDX_W'(chain_out.slot);
                        addr_next        = chain_out.addr;
                        port_next        = chain_out.port;
                        count_next       = count_reg + 1'b1;
                        have_auth_next   = 1'b1;
                        last_term_next   = term_reg;
                        last_epoch_next  = epoch_reg;
                        last_leader_next = leader_reg;
                    end
                end
            end
            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            launch_reg       <= 1'b0;
            have_auth_reg    <= 1'b0;
            last_term_reg    <= '0;
            last_epoch_reg   <= '0;
            last_leader_reg  <= '0;
            count_reg        <= '0;
            group_high_reg   <= '0;
            group_low_reg    <= '0;
            initial_node_reg <= 64'd1;
            min_epoch_reg    <= 64'd1;
            limit_reg        <= COUNT_W'(1);
            route_count_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            launch_reg      <= launch_next;
            have_auth_reg   <= have_auth_next;
            last_term_reg   <= last_term_next;
            last_epoch_reg  <= last_epoch_next;
            last_leader_reg <= last_leader_next;
            count_reg       <= count_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_GROUP_HIGH:     group_high_reg   <= cfg.data;
                    REG_GROUP_LOW:      group_low_reg    <= cfg.data;
                    REG_INITIAL_NODE:   initial_node_reg <= cfg.data;
                    REG_MINIMUM_EPOCH:  min_epoch_reg    <= cfg.data;
                    REG_REDIRECT_LIMIT: limit_reg        <= cfg.data[COUNT_W-1:0];
                    REG_ROUTE_COUNT:    route_count_reg  <= cfg.data[4:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        slot_reg   <= slot_next;
        addr_reg   <= addr_next;
        port_reg   <= port_next;
        if (accept)
        begin
            leader_reg <= req.leader_node;
            term_reg   <= req.term_in;
            epoch_reg  <= req.epoch_in;
        end
    end

`ifndef SYNTH
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !rsp.valid)
        else $error("item accepted while a result is pending");

    a_token_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.active |-> (state_reg == S_SEARCH))
        else $error("search token left the chain outside a search");

    a_count_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("redirect count moved by other than one");

    a_count_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (rsp.valid && status_reg == ST_OK))
        else $error("redirect count moved without an accepted redirect");
`endif

endmodule
